// ===== src/mtwm_pkg.sv =====
package mtwm_pkg;

  localparam int unsigned MAX_TONES        = 8;
  localparam int unsigned SINE_TABLE_DEPTH = 1024;

  localparam int unsigned IDX_W     = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned QUARTER   = SINE_TABLE_DEPTH / 4;
  localparam int unsigned QTR_W     = IDX_W - 2;
  localparam int unsigned CNT_W     = $clog2(MAX_TONES + 1);
  localparam int unsigned SUM_W     = 20;
  localparam int unsigned DUTY_W    = 17;
  localparam int unsigned WAVE_W    = 3;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned TONES_W   = 4;
  localparam int unsigned SINE_W    = 31;
  localparam int unsigned DIV_W     = 18;
  localparam int unsigned DIV_STEPS = DIV_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // waveform codes
  localparam logic [WAVE_W-1:0] WAVE_SILENCE  = 3'd0;
  localparam logic [WAVE_W-1:0] WAVE_SINE     = 3'd1;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 3'd2;
  localparam logic [WAVE_W-1:0] WAVE_SAWTOOTH = 3'd3;
  localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 3'd4;

  // register indexes
  localparam logic REG_WAVEFORM   = 1'b0;
  localparam logic REG_DUTY_CYCLE = 1'b1;

  localparam logic [WAVE_W-1:0] WAVE_RESET = WAVE_SINE;
  localparam logic [DUTY_W-1:0] DUTY_RESET = 17'd32768;
  localparam logic [DUTY_W-1:0] DUTY_FULL  = 17'd65536;

  typedef logic [SINE_W-1:0] sine_lut_t [QUARTER];

  typedef struct packed {
    logic latch;
    logic calc_phase;
    logic set_ovf;
    logic eval;
    logic div_step;
    logic acc;
    logic load_avg;
    logic emit;
  } mtwm_cmd_t;

  typedef struct packed {
    logic freq_zero;
    logic count_full;
    logic use_div;
    logic last;
    logic count_zero;
    logic out_free;
  } mtwm_stat_t;

  // quarter-wave sine, Q30, for the fraction k of a quarter turn
  function automatic logic [SINE_W-1:0] sine_q30(int unsigned k);
    logic [63:0] u, theta, x2, t, s;
    u     = ((64'(k) * 64'd4) << 30) / 64'(SINE_TABLE_DEPTH);
    theta = (u * HALF_PI_Q30) >> 30;
    x2    = (theta * theta) >> 30;
    t     = Q30_ONE - x2 / 64'd72;
    t     = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t     = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t     = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s     = (theta * t) >> 30;
    if (s > Q30_ONE) begin
      s = Q30_ONE;
    end
    return s[SINE_W-1:0];
  endfunction

  function automatic sine_lut_t build_sine_lut();
    sine_lut_t lut;
    for (int unsigned k = 0; k < QUARTER; k++) begin
      lut[k] = sine_q30(k);
    end
    return lut;
  endfunction

  localparam sine_lut_t         SINE_LUT = build_sine_lut();
  localparam logic [SINE_W-1:0] SINE_TOP = sine_q30(QUARTER);

endpackage

// ===== src/mtwm_ifs.sv =====
interface mtwm_tone_if;
  logic        valid;
  logic        ready;
  logic [63:0] time_us;
  logic [30:0] frequency;
  logic        last_tone;

  modport source (output valid, time_us, frequency, last_tone, input ready);
  modport sink   (input valid, time_us, frequency, last_tone, output ready);
endinterface

interface mtwm_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample;
  logic [3:0]  tone_tally;
  logic        tone_overflow;

  modport source (output valid, sample, tone_tally, tone_overflow, input ready);
  modport sink   (input valid, sample, tone_tally, tone_overflow, output ready);
endinterface

// ===== src/multi_tone_waveform_mixer_unit.sv =====
// One tone at a time. Ungated sawtooth and triangle tones pass through the 18-step shared
// restoring divider; a zero-frequency or overflowing tone skips shaping and accumulation.
// After a last tone the divider forms the average when tones were used, and the new
// result waits until any earlier result is taken.
// The result sits in an output register; a new tone is taken while it waits.
// Asynchronous active-low reset: waveform sine, duty cycle one half, accumulators clear.
module multi_tone_waveform_mixer_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mtwm_tone_if.sink            tone_in,
  mtwm_result_if.source        result_out,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [16:0]          cfg_wdata_i
);
  import mtwm_pkg::*;

  mtwm_cmd_t  cmd;
  mtwm_stat_t stat;

  // sequencer
  mtwm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (tone_in.valid),
    .in_ready_o (tone_in.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // arithmetic and storage
  mtwm_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .time_us_i       (tone_in.time_us),
    .frequency_i     (tone_in.frequency),
    .last_tone_i     (tone_in.last_tone),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (result_out.valid),
    .out_ready_i     (result_out.ready),
    .sample_o        (result_out.sample),
    .tone_tally_o    (result_out.tone_tally),
    .tone_overflow_o (result_out.tone_overflow)
  );

endmodule

// ===== src/mtwm_ctrl.sv =====
module mtwm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mtwm_pkg::mtwm_stat_t stat_i,
  output mtwm_pkg::mtwm_cmd_t  cmd_o
);
  import mtwm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PHASE = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_ACC   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_AVG   = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

  logic [2:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  // sequence one tone through phase, shape, divide, accumulate and emit
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_PHASE;
        end
      end
      S_PHASE: begin
        cmd_o.calc_phase = 1'b1;
        if (stat_i.freq_zero) begin
          state_d = S_FIN;
        end else if (stat_i.count_full) begin
          cmd_o.set_ovf = 1'b1;
          state_d       = S_FIN;
        end else begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        step_d     = '0;
        state_d    = stat_i.use_div ? S_DIV : S_ACC;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == STEP_LAST) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (!stat_i.last) begin
          state_d = S_IDLE;
        end else if (stat_i.count_zero) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.load_avg = 1'b1;
          step_d         = '0;
          state_d        = S_AVG;
        end
      end
      S_AVG: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == STEP_LAST) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

// ===== src/mtwm_datapath.sv =====
module mtwm_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [16:0]           cfg_wdata_i,
  input  logic [63:0]           time_us_i,
  input  logic [30:0]           frequency_i,
  input  logic                  last_tone_i,
  input  mtwm_pkg::mtwm_cmd_t   cmd_i,
  output mtwm_pkg::mtwm_stat_t  stat_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [15:0]           sample_o,
  output logic [3:0]            tone_tally_o,
  output logic                  tone_overflow_o
);
  import mtwm_pkg::*;

  logic [WAVE_W-1:0]   wave_q;
  logic [DUTY_W-1:0]   duty_q;
  logic [31:0]         time_q;
  logic [30:0]         freq_q;
  logic                last_q;
  logic [31:0]         phase_q;
  logic                gated_q;
  logic [SINE_W-1:0]   sine_q;
  logic [SUM_W-1:0]    sum_q;
  logic [CNT_W-1:0]    count_q;
  logic                ovf_q;
  logic [DIV_W-1:0]    rem_q, quo_q;
  logic [DUTY_W-1:0]   den_q;
  logic                out_valid_q;
  logic [15:0]         sample_q;
  logic [3:0]          tones_q;
  logic                tovf_q;

  logic [62:0]         product;
  logic [DUTY_W-1:0]   duty_eff;
  logic                gated;
  logic [32:0]         dividend;
  logic [IDX_W-1:0]    sine_idx;
  logic [QTR_W:0]      sine_k;
  logic [SINE_W-1:0]   sine_s;
  logic [DIV_W-1:0]    trial;
  logic [31:0]         sine_v;
  logic [31:0]         sine_r;
  logic [DIV_W-1:0]    tri_c;
  logic [15:0]         comp;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= WAVE_RESET;
      duty_q <= DUTY_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WAVEFORM:   wave_q <= cfg_wdata_i[WAVE_W-1:0];
        REG_DUTY_CYCLE: duty_q <= cfg_wdata_i;
        default:        ;
      endcase
    end
  end

  // phase and gating
  assign product  = time_q * freq_q;
  assign duty_eff = (duty_q > DUTY_FULL) ? DUTY_FULL : duty_q;
  assign gated    = (duty_eff == '0) || ({1'b0, phase_q} > {duty_eff, 16'd0});
  assign dividend = (wave_q == WAVE_SAWTOOTH) ? {1'b0, phase_q} : {phase_q, 1'b0};

  // quarter-wave table lookup, mirrored on odd quadrants
  assign sine_idx = phase_q[31 -: IDX_W];
  assign sine_k   = sine_idx[IDX_W-2] ? ((QTR_W+1)'(QUARTER) - {1'b0, sine_idx[QTR_W-1:0]})
                                      : {1'b0, sine_idx[QTR_W-1:0]};
  assign sine_s   = sine_k[QTR_W] ? SINE_TOP : SINE_LUT[sine_k[QTR_W-1:0]];

  assign trial = {rem_q[DIV_W-2:0], quo_q[DIV_W-1]};

  // component shaping
  always_comb begin
    sine_v = phase_q[31] ? (32'(Q30_ONE) - 32'(sine_q)) : (32'(Q30_ONE) + 32'(sine_q));
    sine_r = (sine_v + 32'd16384) >> 15;
    tri_c  = (quo_q > 18'd65536) ? (18'd131072 - quo_q) : quo_q;
    comp   = '0;
    case (wave_q)
      WAVE_SINE:     comp = (sine_r > 32'd65535) ? 16'hFFFF : sine_r[15:0];
      WAVE_SQUARE:   comp = gated_q ? 16'd0 : 16'hFFFF;
      WAVE_SAWTOOTH: comp = gated_q ? 16'd0 : ((quo_q > 18'd65535) ? 16'hFFFF : quo_q[15:0]);
      WAVE_TRIANGLE: comp = gated_q ? 16'd0 : ((tri_c > 18'd65535) ? 16'hFFFF : tri_c[15:0]);
      default:       comp = '0;
    endcase
  end

  // tone operands and intermediate values
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      time_q <= time_us_i[31:0];
      freq_q <= frequency_i;
      last_q <= last_tone_i;
    end
    if (cmd_i.calc_phase) begin
      phase_q <= product[31:0];
    end
    if (cmd_i.eval) begin
      gated_q <= gated;
      sine_q  <= sine_s;
      rem_q   <= {3'd0, dividend[32:DIV_W]};
      quo_q   <= dividend[DIV_W-1:0];
      den_q   <= duty_eff;
    end else if (cmd_i.load_avg) begin
      // top sum bits start the remainder, the rest shift in
      rem_q <= DIV_W'(sum_q[SUM_W-1:DIV_W]);
      quo_q <= sum_q[DIV_W-1:0];
      den_q <= DUTY_W'(count_q);
    end else if (cmd_i.div_step) begin
      if (trial >= {1'b0, den_q}) begin
        rem_q <= trial - {1'b0, den_q};
        quo_q <= {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[DIV_W-2:0], 1'b0};
      end
    end
  end

  // chord accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.emit) begin
      sum_q   <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      if (cmd_i.acc) begin
        sum_q   <= sum_q + SUM_W'(comp);
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.set_ovf) begin
        ovf_q <= 1'b1;
      end
    end
  end

  // result register, hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      sample_q <= (count_q == '0) ? 16'd0 : quo_q[15:0];
      tones_q  <= 4'(count_q);
      tovf_q   <= ovf_q;
    end
  end

  assign stat_o.freq_zero  = (freq_q == '0);
  assign stat_o.count_full = (count_q >= CNT_W'(MAX_TONES));
  assign stat_o.use_div    = ((wave_q == WAVE_SAWTOOTH) || (wave_q == WAVE_TRIANGLE)) && !gated;
  assign stat_o.last       = last_q;
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign sample_o        = sample_q;
  assign tone_tally_o    = tones_q;
  assign tone_overflow_o = tovf_q;

endmodule

// ===== src/mtwm_checker.sv =====
module mtwm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] sample,
  input logic [3:0]  tone_tally
);
  import mtwm_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(sample))
    else $error("result dropped while stalled");

  // take one tone at a time
  a_one_tone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("tone accepted back to back");

  // never report more tones than the chord may hold
  a_tone_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> tone_tally <= 4'(MAX_TONES))
    else $error("tone count above limit");

  // silent chord gives a zero sample
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && tone_tally == 4'd0 |-> sample == 16'd0)
    else $error("empty chord with nonzero sample");

endmodule

bind multi_tone_waveform_mixer_unit mtwm_checker u_mtwm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (tone_in.valid),
  .in_ready   (tone_in.ready),
  .out_valid  (result_out.valid),
  .out_ready  (result_out.ready),
  .sample     (result_out.sample),
  .tone_tally (result_out.tone_tally)
);
